// ----- rtl/core/sblc_pkg.sv -----
// Package: shared constants, result codes and sequencer states of the LRU tag store.
`timescale 1ns / 1ps
`default_nettype none
package sblc_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 16;

    localparam int SIZE_W = 32;
    localparam int VKEY_W = 16;
    localparam int KIND_W = 3;

    localparam logic [SIZE_W-1:0] BUDGET_RESET = 32'd16777216;

    localparam logic [KIND_W-1:0] KIND_HIT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOADED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OOM     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EVICT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FLUSHED = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUSH,
        S_LOOK,
        S_HIT,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_EVICT
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/core/sblc_req_if.sv -----
// Interface: request channel (action, key, resource size).
`timescale 1ns / 1ps
`default_nettype none
interface sblc_req_if #(
    parameter int KEY_BITS = sblc_pkg::KEY_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [KEY_BITS-1:0]         key;
    logic [sblc_pkg::SIZE_W-1:0] resource_size;

    modport source (output valid, action, key, resource_size, input ready);
    modport sink   (input valid, action, key, resource_size, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sblc_rsp_if.sv -----
// Interface: result channel (kind, victim, bytes in use, last flag).
`timescale 1ns / 1ps
`default_nettype none
interface sblc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [sblc_pkg::KIND_W-1:0] kind;
    logic [sblc_pkg::VKEY_W-1:0] victim_key;
    logic [sblc_pkg::SIZE_W-1:0] victim_size;
    logic [sblc_pkg::SIZE_W-1:0] bytes_in_use;
    logic                        last;

    modport source (output valid, kind, victim_key, victim_size, bytes_in_use, last,
                    input ready);
    modport sink   (input valid, kind, victim_key, victim_size, bytes_in_use, last,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sblc_cfg_if.sv -----
// Interface: configuration write channel for the byte budget.
`timescale 1ns / 1ps
`default_nettype none
interface sblc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sblc_pkg::SIZE_W-1:0] budget_bytes;

    modport source (output valid, budget_bytes, input ready);
    modport sink   (input valid, budget_bytes, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/size_budget_lru_cache_top.sv -----
// Top level: byte-budgeted LRU cache tag store with a sequential entry walker.
// Usage:
//   i_req  - request transactions: action 0 looks up key (size used on a miss),
//            action 1 flushes every entry. Ready only while the sequencer idles.
//   o_rsp  - result transactions: one or more per request, the final one flagged
//            by last. Eviction notices (kind 3) precede the load or failure result.
//   i_cfg  - budget write channel, always ready; write it only while idle.
// Walk: the tag RAM has one read port, so lookup and LRU search walk one entry
//   per cycle; a load runs a fresh search after each eviction notice.
// The result register frees the request side: a new request is taken while the
// final result of the previous one still waits. When the receiver stalls, the
// sequencer holds at the next result until the register drains.
// Reset (synchronous, active low) empties the cache, zeroes bytes in use and
// restores the budget to 16 MiB. Key and size storage need no clearing pass:
// entries are read only while their valid bit is set.
`timescale 1ns / 1ps
`default_nettype none
module size_budget_lru_cache_top #(
    parameter int ENTRIES  = sblc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = sblc_pkg::KEY_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sblc_req_if.sink   i_req,
    sblc_rsp_if.source o_rsp,
    sblc_cfg_if.sink   i_cfg
);
    localparam int IW    = $clog2(ENTRIES);
    localparam int SW    = sblc_pkg::SIZE_W;
    localparam int RAM_W = KEY_BITS + SW;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [IW:0]   MAX_NOTES = (IW + 1)'(ENTRIES);

    // Sequencer and request registers
    sblc_pkg::t_state r_state, n_state;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [SW-1:0]       r_size, n_size;
    logic [SW-1:0]       r_budget, n_budget;
    logic [SW-1:0]       r_used, n_used;

    // Walk state
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_pidx, n_pidx;
    logic          r_pend, n_pend;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic          r_free_found, n_free_found;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic          r_vic_found, n_vic_found;
    logic [IW-1:0] r_vic_idx, n_vic_idx;
    logic [IW-1:0] r_vic_age, n_vic_age;
    logic [IW:0]   r_notes, n_notes;

    // Per-entry valid bits and recency ranks (0 = most recent)
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [IW-1:0]      r_age [ENTRIES];
    logic [IW-1:0]      n_age [ENTRIES];

    // Result register
    logic                          r_out_valid, n_out_valid;
    logic [sblc_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [sblc_pkg::VKEY_W-1:0]   r_vkey, n_vkey;
    logic [SW-1:0]                 r_vsize, n_vsize;
    logic [SW-1:0]                 r_bytes, n_bytes;
    logic                          r_last, n_last;

    // Tag RAM
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [IW-1:0]    ram_raddr;
    logic [RAM_W-1:0] ram_rdata;

    logic                  req_take;
    logic                  can_emit;
    logic                  key_match;
    logic                  look_done;
    logic                  fits;
    logic                  give_up;
    logic [KEY_BITS-1:0]   rd_key;
    logic [SW-1:0]         rd_size;
    logic [KEY_BITS+15:0]  rd_key_ext;
    logic [SW-1:0]         used_less;

    sblc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready  = (r_state == sblc_pkg::S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign req_take     = i_req.valid && i_req.ready;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.kind         = r_kind;
    assign o_rsp.victim_key   = r_vkey;
    assign o_rsp.victim_size  = r_vsize;
    assign o_rsp.bytes_in_use = r_bytes;
    assign o_rsp.last         = r_last;

    // A result may be loaded when the register is empty or drains this cycle
    assign can_emit = !r_out_valid || o_rsp.ready;

    assign rd_key     = ram_rdata[RAM_W-1:SW];
    assign rd_size    = ram_rdata[SW-1:0];
    assign rd_key_ext = {16'b0, rd_key};

    assign key_match = r_pend && r_valid[r_pidx] && (rd_key == r_key);
    assign look_done = r_pend && (r_pidx == LAST_IDX);
    // Room left is zero when use already meets or exceeds the budget
    assign fits      = r_free_found &&
                       (r_size <= ((r_used >= r_budget) ? '0 : r_budget - r_used));
    assign give_up   = !r_vic_found || (r_notes >= MAX_NOTES);
    assign used_less = (r_used >= rd_size) ? r_used - rd_size : '0;

    // Walk the RAM by index during lookup, else hold the victim address
    assign ram_raddr = (r_state == sblc_pkg::S_LOOK) ? r_idx : r_vic_idx;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sblc_pkg::S_IDLE: begin
                if (req_take) begin
                    n_state = i_req.action ? sblc_pkg::S_FLUSH : sblc_pkg::S_LOOK;
                end
            end
            sblc_pkg::S_FLUSH: begin
                if (can_emit) begin
                    n_state = sblc_pkg::S_IDLE;
                end
            end
            sblc_pkg::S_LOOK: begin
                if (key_match) begin
                    n_state = sblc_pkg::S_HIT;
                end else if (look_done) begin
                    n_state = sblc_pkg::S_CHECK;
                end
            end
            sblc_pkg::S_HIT: begin
                if (can_emit) begin
                    n_state = sblc_pkg::S_IDLE;
                end
            end
            sblc_pkg::S_CHECK: begin
                if (r_size > r_budget) begin
                    if (can_emit) begin
                        n_state = sblc_pkg::S_IDLE;
                    end
                end else begin
                    n_state = sblc_pkg::S_SCAN;
                end
            end
            sblc_pkg::S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = sblc_pkg::S_DECIDE;
                end
            end
            sblc_pkg::S_DECIDE: begin
                if (fits || give_up) begin
                    if (can_emit) begin
                        n_state = sblc_pkg::S_IDLE;
                    end
                end else begin
                    n_state = sblc_pkg::S_EVICT;
                end
            end
            sblc_pkg::S_EVICT: begin
                if (can_emit) begin
                    n_state = sblc_pkg::S_SCAN;
                end
            end
            default: n_state = sblc_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_key        = r_key;
        n_size       = r_size;
        n_budget     = r_budget;
        n_used       = r_used;
        n_idx        = r_idx;
        n_pidx       = r_pidx;
        n_pend       = r_pend;
        n_hit_idx    = r_hit_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_vic_found  = r_vic_found;
        n_vic_idx    = r_vic_idx;
        n_vic_age    = r_vic_age;
        n_notes      = r_notes;
        n_valid      = r_valid;
        n_age        = r_age;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_kind       = r_kind;
        n_vkey       = r_vkey;
        n_vsize      = r_vsize;
        n_bytes      = r_bytes;
        n_last       = r_last;
        ram_we       = 1'b0;
        ram_waddr    = r_free_idx;
        ram_wdata    = {r_key, r_size};

        if (i_cfg.valid && i_cfg.ready) begin
            n_budget = i_cfg.budget_bytes;
        end

        unique case (r_state)
            sblc_pkg::S_IDLE: begin
                if (req_take) begin
                    n_key    = i_req.key;
                    n_size   = i_req.resource_size;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_notes  = '0;
                end
            end
            sblc_pkg::S_FLUSH: begin
                if (can_emit) begin
                    n_valid     = '0;
                    n_used      = '0;
                    n_out_valid = 1'b1;
                    n_kind      = sblc_pkg::KIND_FLUSHED;
                    n_vkey      = '0;
                    n_vsize     = '0;
                    n_bytes     = '0;
                    n_last      = 1'b1;
                end
            end
            sblc_pkg::S_LOOK: begin
                // Issue the next read while comparing the previous one
                n_pidx    = r_idx;
                n_pend    = 1'b1;
                n_idx     = r_idx + IW'(1);
                n_hit_idx = r_pidx;
            end
            sblc_pkg::S_HIT: begin
                if (can_emit) begin
                    // Promote the hit entry; age the more recent ones by one
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r_valid[i] && (IW'(i) != r_hit_idx) &&
                            (r_age[i] < r_age[r_hit_idx])) begin
                            n_age[i] = r_age[i] + IW'(1);
                        end
                    end
                    n_age[r_hit_idx] = '0;
                    n_out_valid = 1'b1;
                    n_kind      = sblc_pkg::KIND_HIT;
                    n_vkey      = '0;
                    n_vsize     = '0;
                    n_bytes     = r_used;
                    n_last      = 1'b1;
                end
            end
            sblc_pkg::S_CHECK: begin
                if (r_size > r_budget) begin
                    if (can_emit) begin
                        n_out_valid = 1'b1;
                        n_kind      = sblc_pkg::KIND_OOM;
                        n_vkey      = '0;
                        n_vsize     = '0;
                        n_bytes     = r_used;
                        n_last      = 1'b1;
                    end
                end else begin
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_vic_found  = 1'b0;
                end
            end
            sblc_pkg::S_SCAN: begin
                // Track first free slot and oldest valid entry
                if (!r_valid[r_idx]) begin
                    if (!r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_idx;
                    end
                end else if (!r_vic_found || (r_age[r_idx] > r_vic_age)) begin
                    n_vic_found = 1'b1;
                    n_vic_idx   = r_idx;
                    n_vic_age   = r_age[r_idx];
                end
                n_idx = r_idx + IW'(1);
            end
            sblc_pkg::S_DECIDE: begin
                if (fits) begin
                    if (can_emit) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (r_valid[i]) begin
                                n_age[i] = r_age[i] + IW'(1);
                            end
                        end
                        n_age[r_free_idx]   = '0;
                        n_valid[r_free_idx] = 1'b1;
                        ram_we      = 1'b1;
                        n_used      = r_used + r_size;
                        n_out_valid = 1'b1;
                        n_kind      = sblc_pkg::KIND_LOADED;
                        n_vkey      = '0;
                        n_vsize     = '0;
                        n_bytes     = r_used + r_size;
                        n_last      = 1'b1;
                    end
                end else if (give_up) begin
                    if (can_emit) begin
                        n_out_valid = 1'b1;
                        n_kind      = sblc_pkg::KIND_OOM;
                        n_vkey      = '0;
                        n_vsize     = '0;
                        n_bytes     = r_used;
                        n_last      = 1'b1;
                    end
                end
            end
            sblc_pkg::S_EVICT: begin
                if (can_emit) begin
                    // Drop the victim and take its bytes off the bytes in use
                    n_valid[r_vic_idx] = 1'b0;
                    n_used       = used_less;
                    n_notes      = r_notes + (IW + 1)'(1);
                    n_out_valid  = 1'b1;
                    n_kind       = sblc_pkg::KIND_EVICT;
                    n_vkey       = rd_key_ext[15:0];
                    n_vsize      = rd_size;
                    n_bytes      = used_less;
                    n_last       = 1'b0;
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_vic_found  = 1'b0;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !o_rsp.ready;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sblc_pkg::S_IDLE;
            r_budget    <= sblc_pkg::BUDGET_RESET;
            r_used      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_notes     <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_budget    <= n_budget;
            r_used      <= n_used;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_notes     <= n_notes;
            r_age       <= n_age;
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_size       <= n_size;
        r_idx        <= n_idx;
        r_pidx       <= n_pidx;
        r_hit_idx    <= n_hit_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_vic_found  <= n_vic_found;
        r_vic_idx    <= n_vic_idx;
        r_vic_age    <= n_vic_age;
        r_kind       <= n_kind;
        r_vkey       <= n_vkey;
        r_vsize      <= n_vsize;
        r_bytes      <= n_bytes;
        r_last       <= n_last;
    end

endmodule
`default_nettype wire

// ----- rtl/core/sblc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sblc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- verif/size_budget_lru_cache_top_tb.sv -----
// Testbench: random and directed requests and flushes through the LRU tag store, checked per result.
`timescale 1ns / 1ps
module size_budget_lru_cache_top_tb;

    localparam int ENTRIES    = sblc_pkg::ENTRIES_DEF;
    localparam int KEY_BITS   = sblc_pkg::KEY_BITS_DEF;
    localparam int SIZE_W     = sblc_pkg::SIZE_W;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_ITEMS = 80;

    typedef struct packed {
        logic [sblc_pkg::KIND_W-1:0] kind;
        logic [sblc_pkg::VKEY_W-1:0] victim_key;
        logic [SIZE_W-1:0]           victim_size;
        logic [SIZE_W-1:0]           bytes_in_use;
        logic                        last;
    } t_cache_outcome;

    // Shadow copy of the tag store; every accepted request is replayed here and
    // the outcomes it must produce are queued in order.
    class t_outcome_book;
        logic [SIZE_W-1:0]   budget;
        bit                  held [ENTRIES];
        logic [KEY_BITS-1:0] tag [ENTRIES];
        logic [SIZE_W-1:0]   bytes [ENTRIES];
        int unsigned         rank [ENTRIES];
        logic [SIZE_W-1:0]   in_use;
        t_cache_outcome      pending_outcomes [$];

        function void clear();
            budget = sblc_pkg::BUDGET_RESET;
            in_use = '0;
            pending_outcomes.delete();
            for (int i = 0; i < ENTRIES; i++) begin
                held[i]  = 1'b0;
                tag[i]   = '0;
                bytes[i] = '0;
                rank[i]  = 0;
            end
        endfunction

        function void set_budget(logic [SIZE_W-1:0] b);
            budget = b;
        endfunction

        function void queue_outcome(logic [sblc_pkg::KIND_W-1:0] k,
                                    logic [sblc_pkg::VKEY_W-1:0] vk,
                                    logic [SIZE_W-1:0] vs, logic l);
            t_cache_outcome o;
            o.kind         = k;
            o.victim_key   = vk;
            o.victim_size  = vs;
            o.bytes_in_use = in_use;
            o.last         = l;
            pending_outcomes.push_back(o);
        endfunction

        function void note_request(logic flush, logic [KEY_BITS-1:0] key,
                                   logic [SIZE_W-1:0] size);
            int                hit_at;
            int                free_slot;
            int                victim;
            int                notices;
            int unsigned       old_rank;
            logic [SIZE_W-1:0] avail;
            hit_at  = -1;
            notices = 0;
            if (flush) begin
                for (int i = 0; i < ENTRIES; i++) held[i] = 1'b0;
                in_use = '0;
                queue_outcome(sblc_pkg::KIND_FLUSHED, '0, '0, 1'b1);
                return;
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (hit_at < 0 && held[i] && tag[i] == key) hit_at = i;
            end
            if (hit_at >= 0) begin
                // promote to most recent, shifting only the younger entries
                old_rank = rank[hit_at];
                for (int i = 0; i < ENTRIES; i++) begin
                    if (held[i] && i != hit_at && rank[i] < old_rank) rank[i]++;
                end
                rank[hit_at] = 0;
                queue_outcome(sblc_pkg::KIND_HIT, '0, '0, 1'b1);
                return;
            end
            if (size > budget) begin
                queue_outcome(sblc_pkg::KIND_OOM, '0, '0, 1'b1);
                return;
            end
            while (1'b1) begin
                free_slot = -1;
                victim    = -1;
                avail     = (in_use >= budget) ? '0 : budget - in_use;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!held[i]) begin
                        if (free_slot < 0) free_slot = i;
                    end else if (victim < 0 || rank[i] > rank[victim]) begin
                        victim = i;
                    end
                end
                if (size <= avail && free_slot >= 0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (held[i]) rank[i]++;
                    end
                    held[free_slot]  = 1'b1;
                    tag[free_slot]   = key;
                    bytes[free_slot] = size;
                    rank[free_slot]  = 0;
                    in_use           = in_use + size;
                    queue_outcome(sblc_pkg::KIND_LOADED, '0, '0, 1'b1);
                    return;
                end
                if (victim < 0 || notices >= ENTRIES) begin
                    queue_outcome(sblc_pkg::KIND_OOM, '0, '0, 1'b1);
                    return;
                end
                held[victim] = 1'b0;
                in_use = (in_use >= bytes[victim]) ? in_use - bytes[victim] : '0;
                queue_outcome(sblc_pkg::KIND_EVICT, sblc_pkg::VKEY_W'(tag[victim]),
                              bytes[victim], 1'b0);
                notices++;
            end
        endfunction

        // Empty string when the outcome matches the oldest one queued.
        function string check_outcome(t_cache_outcome got);
            t_cache_outcome want;
            string          msg;
            msg = "";
            if (pending_outcomes.size() == 0)
                return $sformatf("result kind %0d with none expected", got.kind);
            want = pending_outcomes[0];
            pending_outcomes.delete(0);
            if (got.kind !== want.kind)
                msg = {msg, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
            if (got.victim_key !== want.victim_key)
                msg = {msg, $sformatf(" victim_key %0h/%0h", got.victim_key,
                                      want.victim_key)};
            if (got.victim_size !== want.victim_size)
                msg = {msg, $sformatf(" victim_size %0h/%0h", got.victim_size,
                                      want.victim_size)};
            if (got.bytes_in_use !== want.bytes_in_use)
                msg = {msg, $sformatf(" bytes_in_use %0h/%0h", got.bytes_in_use,
                                      want.bytes_in_use)};
            if (got.last !== want.last)
                msg = {msg, $sformatf(" last %0b/%0b", got.last, want.last)};
            if (msg != "") msg = {"got/want:", msg};
            return msg;
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sblc_req_if #(.KEY_BITS(KEY_BITS)) req_if ();
    sblc_rsp_if                        rsp_if ();
    sblc_cfg_if                        cfg_if ();

    size_budget_lru_cache_top #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    t_outcome_book       book;
    int                  n_errors;
    int                  idle_cycles;
    int                  rsp_hold;
    int                  rsp_gap;
    bit                  steady;
    logic [KEY_BITS-1:0] key_pool [24];
    int                  pool_n;
    t_cache_outcome      seen;
    string               verdict;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Drive every input to a known value before the first edge.
    initial begin
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.action        = 1'b0;
        req_if.key           = '0;
        req_if.resource_size = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.budget_bytes  = '0;
        rsp_if.ready         = 1'b0;
        n_errors             = 0;
        idle_cycles          = 0;
        rsp_hold             = 0;
        steady               = 1'b0;
        pool_n               = 1;
        book                 = new;
        book.clear();
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 60) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold valid across back-to-back transactions; lower it only for a real gap
    // so that valid never sees two updates in one step.
    task automatic send_item(input logic act, input logic [KEY_BITS-1:0] key,
                             input logic [SIZE_W-1:0] size);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.action        <= act;
        req_if.key           <= key;
        req_if.resource_size <= size;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        book.note_request(act, key, size);
    endtask

    // Let the block drain completely, then write the budget.
    task automatic write_budget(input logic [SIZE_W-1:0] b);
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending() != 0) @(posedge i_clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.budget_bytes <= b;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        book.set_budget(b);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic random_item(input logic [SIZE_W-1:0] budget);
        int                  r;
        int                  s;
        logic [KEY_BITS-1:0] key;
        logic [SIZE_W-1:0]   size;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, pool_n - 1)];
        else key = KEY_BITS'($urandom());
        if (s < 6) size = '0;
        else if (s < 12) size = $urandom();
        else if (s < 16) size = budget;
        else if (s < 19 && budget != '1) size = budget + 1;
        else size = $urandom_range(0, budget / $urandom_range(1, 16));
        if ($urandom_range(0, 29) == 0) steady <= ~steady;
        if (r < 4) send_item(1'b1, KEY_BITS'($urandom()), $urandom());
        else send_item(1'b0, key, size);
    endtask

    // Response side: check each accepted result, then pick ready for the next edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rsp_hold     <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                seen.kind         = rsp_if.kind;
                seen.victim_key   = rsp_if.victim_key;
                seen.victim_size  = rsp_if.victim_size;
                seen.bytes_in_use = rsp_if.bytes_in_use;
                seen.last         = rsp_if.last;
                verdict = book.check_outcome(seen);
                if (verdict != "") report_mismatch(verdict);
            end
            if (rsp_hold > 0) begin
                rsp_hold     <= rsp_hold - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                if (rsp_gap > 0) begin
                    rsp_hold     <= rsp_gap - 1;
                    rsp_if.ready <= 1'b0;
                end else begin
                    rsp_if.ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: count edges at which no channel moves a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                     (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("size_budget_lru_cache_top_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [SIZE_W-1:0] budgets [6];
        logic [SIZE_W-1:0] cur;
        budgets[0] = 32'd1000;
        budgets[1] = 32'hFFFF_FFFF;
        budgets[2] = 32'd300;      // lands far below what the previous phase holds
        budgets[3] = 32'd0;
        budgets[4] = $urandom();
        budgets[5] = sblc_pkg::BUDGET_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset budget of 16 MiB.
        send_item(1'b1, 16'hFFFF, 32'hFFFF_FFFF);   // flush of an empty cache, fields ignored
        send_item(1'b0, 16'h0000, 32'd0);           // zero size loads into a free slot
        send_item(1'b0, 16'h0000, 32'hFFFF_FFFF);   // hit ignores the size
        send_item(1'b0, 16'hFFFF, 32'hFFFF_FFFF);   // above budget fails at once
        send_item(1'b0, 16'hFFFF, sblc_pkg::BUDGET_RESET);    // exactly the budget
        send_item(1'b0, 16'h0001, 32'd1);           // evicts both older entries
        for (int k = 2; k <= ENTRIES; k++) send_item(1'b0, KEY_BITS'(k), 32'd0);
        send_item(1'b0, 16'h0011, 32'd0);           // full: evict the oldest for a slot
        write_budget(32'd0);
        send_item(1'b0, 16'h0003, 32'd5);           // hit survives a zero budget
        send_item(1'b0, 16'h0064, 32'd0);           // zero size still needs a slot
        send_item(1'b0, 16'h0065, 32'd1);           // over a zero budget

        // Random phases, one budget each.
        foreach (budgets[p]) begin
            cur = budgets[p];
            write_budget(cur);
            pool_n = $urandom_range(4, 24);
            for (int k = 0; k < pool_n; k++) key_pool[k] = KEY_BITS'($urandom());
            repeat (PHASE_ITEMS) random_item(cur);
        end

        // Drain, then give a late or extra result time to show up.
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending() != 0) @(posedge i_clk);
        repeat (2 * ENTRIES + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("size_budget_lru_cache_top_tb: done, clean");
        end else begin
            $display("size_budget_lru_cache_top_tb: done, errors");
        end
        $finish;
    end

endmodule
